// ----- rtl/core/rmcb_pkg.sv -----
// ----------------------------------------------------------------------------
// rmcb_pkg
// Widths and fixed-point constants for the roughness mip-chain bake.
// ----------------------------------------------------------------------------
package rmcb_pkg;

  localparam int MAX_LOG2   = 10;
  localparam int CNT_W      = 10;
  localparam int LVL_W      = 4;
  localparam int ADDR_W     = 10;
  localparam int NSUM_W     = 26;
  localparam int ASUM_W     = 27;
  localparam int ROW_W      = 3 * NSUM_W + ASUM_W;
  localparam int SQ_W       = 48;

  localparam logic [44:0] ONE44     = 45'h1 << 44;
  localparam logic [44:0] R2_NOSPRD = ONE44 - (45'h1 << 22);
  localparam logic [46:0] THREE44   = 47'h3 << 44;
  localparam logic [24:0] ONE24     = 25'h1 << 24;
  localparam logic [47:0] ALPHA_ONE = 48'h1 << 32;

  localparam logic [1:0] TAG_ALPHA = 2'd0;
  localparam logic [1:0] TAG_R     = 2'd1;
  localparam logic [1:0] TAG_OUT   = 2'd2;

endpackage

// ----- rtl/core/roughness_mip_chain_bake.sv -----
// ----------------------------------------------------------------------------
// roughness_mip_chain_bake
// Mip-chain bake of vMF-widened roughness from level-0 normals and roughness.
// Each beat in yields 1 to 11 results; the work for each result is set by
// the shared 32x32 multiplier and the restoring sqrt/divide loop (one step
// per cycle, 24 steps). Not ready while a beat is in work.
// Reset (rst_n low, synchronous) sets both sizes to 1x1 and the raster to 0,0.
// ----------------------------------------------------------------------------
module roughness_mip_chain_bake
  import rmcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // normal_x, normal_y, normal_z, in_roughness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // mip_level, tex_x, tex_y, out_roughness
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // image_done
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_A2M  = 4'd1;
  localparam logic [3:0] ST_A2R  = 4'd2;
  localparam logic [3:0] ST_A2F  = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_CLS  = 4'd5;
  localparam logic [3:0] ST_SQRT = 4'd6;
  localparam logic [3:0] ST_DEN  = 4'd7;
  localparam logic [3:0] ST_NUM  = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_SSUM = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;
  localparam logic [3:0] ST_RD   = 4'd12;
  localparam logic [3:0] ST_WR   = 4'd13;
  localparam logic [3:0] ST_ADV  = 4'd14;

  logic [ROW_W-1:0] mem [0:(1<<ADDR_W)-1];

  logic [3:0]        state_r, state_nxt;
  logic [LVL_W-1:0]  wl_r, wl_nxt, hl_r, hl_nxt;
  logic [CNT_W-1:0]  cxc_r, cxc_nxt, cyc_r, cyc_nxt;
  logic [15:0]       rough_r, rough_nxt;
  logic signed [23:0] n0_r, n0_nxt, n1_r, n1_nxt, n2_r, n2_nxt;
  logic [24:0]       a2_r, a2_nxt;
  logic [63:0]       prod_r;
  logic [46:0]       acc_r, acc_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [1:0]        tag_r, tag_nxt;
  logic [44:0]       r2_r, r2_nxt;
  logic [23:0]       a2c_r, a2c_nxt;
  logic [22:0]       rt_r, rt_nxt;
  logic [47:0]       den_r, den_nxt, rem_r, rem_nxt;
  logic [23:0]       t_r, t_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [CNT_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [15:0]       orough_r, orough_nxt;
  logic [ROW_W-1:0]  memq_r;

  logic [31:0]       mul_a, mul_b;
  logic              hx, hy, top, first, complete;
  logic [1:0]        sh;
  logic [CNT_W-1:0]  px, py;
  logic [ADDR_W-1:0] idx, dim_up;
  logic [LVL_W-1:0]  lvl_up;
  logic [44:0]       r2c;
  logic [23:0]       a2c;
  logic [SQ_W:0]     strial;
  logic [SQ_W-1:0]   sres_step;
  logic [45:0]       num;
  logic [48:0]       rem2;
  logic [24:0]       ssum;
  logic [63:0]       a2rnd;
  logic signed [NSUM_W-1:0] s0, s1, s2;
  logic [ASUM_W-1:0] sa;
  logic [ROW_W-1:0]  wrow;
  logic [CNT_W:0]    wlast, hlast;
  logic signed [23:0] nsel;
  logic [23:0]       nabs;

  assign hx       = wl_r > lvl_r;
  assign hy       = hl_r > lvl_r;
  assign top      = !hx && !hy;
  assign px       = hx ? (cx_r >> 1) : cx_r;
  assign py       = hy ? (cy_r >> 1) : cy_r;
  assign first    = !(cx_r[0] && hx) && !(cy_r[0] && hy);
  assign complete = (cx_r[0] || !hx) && (cy_r[0] || !hy);
  assign sh       = {1'b0, hx} + {1'b0, hy};
  assign idx      = base_r + px;
  assign lvl_up   = lvl_r + 4'd1;
  assign dim_up   = (wl_r > lvl_up) ? (ADDR_W'(1) << (wl_r - lvl_up)) : ADDR_W'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {orough_r, cy_r, cx_r, lvl_r};
  assign out_tlast  = top || !complete;
  assign out_tuser  = top;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    nsel = n0_r;
      2'd1:    nsel = n1_r;
      default: nsel = n2_r;
    endcase
    nabs = nsel[23] ? 24'(-nsel) : 24'(nsel);
    case (state_r)
      ST_A2M:  mul_a = {16'd0, rough_r};
      ST_A2R:  mul_a = prod_r[31:0];
      ST_DEN:  mul_a = {9'd0, rt_r};
      default: mul_a = {8'd0, nabs};
    endcase
    case (state_r)
      ST_DEN:  mul_b = {8'd0, 24'((THREE44 - {2'd0, r2_r}) >> 22)};
      default: mul_b = mul_a;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
    if (state_r == ST_RD) begin
      memq_r <= mem[idx];
    end
    if (state_r == ST_WR) begin
      mem[idx] <= wrow;
    end
  end

  always_comb begin
    r2c       = (acc_r > {2'd0, ONE44}) ? ONE44 : acc_r[44:0];
    a2c       = (a2_r >= ONE24) ? 24'hFFFFFF : a2_r[23:0];
    strial    = {1'b0, sres_r} + {1'b0, sbit_r};
    sres_step = ({1'b0, sv_r} >= strial) ? (sres_r >> 1) + sbit_r : sres_r >> 1;
    num       = {ONE44 - r2_r, 1'b0};
    rem2      = {rem_r, 1'b0};
    ssum      = {1'b0, a2c_r} + {1'b0, t_r};
    a2rnd     = prod_r + (64'h1 << 39);
    s0 = first ? NSUM_W'(n0_r) : memq_r[25:0]  + NSUM_W'(n0_r);
    s1 = first ? NSUM_W'(n1_r) : memq_r[51:26] + NSUM_W'(n1_r);
    s2 = first ? NSUM_W'(n2_r) : memq_r[77:52] + NSUM_W'(n2_r);
    sa = first ? ASUM_W'(a2_r) : memq_r[104:78] + ASUM_W'(a2_r);
    wrow  = {sa, s2, s1, s0};
    wlast = (11'd1 << wl_r) - 11'd1;
    hlast = (11'd1 << hl_r) - 11'd1;

    state_nxt = state_r;   wl_nxt = wl_r;       hl_nxt = hl_r;
    cxc_nxt = cxc_r;       cyc_nxt = cyc_r;     rough_nxt = rough_r;
    n0_nxt = n0_r;         n1_nxt = n1_r;       n2_nxt = n2_r;
    a2_nxt = a2_r;         acc_nxt = acc_r;     cnt_nxt = cnt_r;
    sv_nxt = sv_r;         sres_nxt = sres_r;   sbit_nxt = sbit_r;
    tag_nxt = tag_r;       r2_nxt = r2_r;       a2c_nxt = a2c_r;
    rt_nxt = rt_r;         den_nxt = den_r;     rem_nxt = rem_r;
    t_nxt = t_r;           lvl_nxt = lvl_r;     cx_nxt = cx_r;
    cy_nxt = cy_r;         base_nxt = base_r;   orough_nxt = orough_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n0_nxt    = 24'($signed(in_tdata[15:0])) <<< 7;
          n1_nxt    = 24'($signed(in_tdata[31:16])) <<< 7;
          n2_nxt    = 24'($signed(in_tdata[47:32])) <<< 7;
          rough_nxt = in_tdata[63:48];
          lvl_nxt   = '0;
          cx_nxt    = cxc_r;
          cy_nxt    = cyc_r;
          base_nxt  = '0;
          state_nxt = ST_A2M;
        end
      end
      ST_A2M: state_nxt = ST_A2R;
      ST_A2R: state_nxt = ST_A2F;
      ST_A2F: begin
        a2_nxt    = {1'b0, a2rnd[63:40]};
        cnt_nxt   = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        acc_nxt = (cnt_r == 5'd0) ? '0 : acc_r + prod_r[46:0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          state_nxt = ST_CLS;
        end
      end
      ST_CLS: begin
        r2_nxt    = r2c;
        a2c_nxt   = a2c;
        sres_nxt  = '0;
        sbit_nxt  = SQ_W'(1) << 46;
        state_nxt = ST_SQRT;
        if (r2c >= R2_NOSPRD) begin
          sv_nxt  = {a2c, 24'd0};
          tag_nxt = TAG_ALPHA;
        end else if (r2c <= 45'd16) begin
          sv_nxt  = ALPHA_ONE;
          tag_nxt = TAG_OUT;
        end else begin
          sv_nxt  = SQ_W'(r2c);
          tag_nxt = TAG_R;
        end
      end
      ST_SQRT: begin
        if ({1'b0, sv_r} >= strial) begin
          sv_nxt = SQ_W'({1'b0, sv_r} - strial);
        end
        sres_nxt = sres_step;
        sbit_nxt = sbit_r >> 2;
        if (sbit_r[0]) begin
          case (tag_r)
            TAG_ALPHA: begin
              sv_nxt   = sres_step << 8;
              sres_nxt = '0;
              sbit_nxt = SQ_W'(1) << 46;
              tag_nxt  = TAG_OUT;
            end
            TAG_R: begin
              rt_nxt    = sres_step[22:0];
              state_nxt = ST_DEN;
            end
            default: begin
              orough_nxt = (sres_step > 48'hFFFF) ? 16'hFFFF : sres_step[15:0];
              state_nxt  = ST_EMIT;
            end
          endcase
        end
      end
      ST_DEN: state_nxt = ST_NUM;
      ST_NUM: begin
        if ({2'd0, num} >= prod_r[47:0]) begin
          sv_nxt    = ALPHA_ONE;
          sres_nxt  = '0;
          sbit_nxt  = SQ_W'(1) << 46;
          tag_nxt   = TAG_OUT;
          state_nxt = ST_SQRT;
        end else begin
          den_nxt   = prod_r[47:0];
          rem_nxt   = {2'd0, num};
          t_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt = 48'(rem2 - {1'b0, den_r});
          t_nxt   = {t_r[22:0], 1'b1};
        end else begin
          rem_nxt = rem2[47:0];
          t_nxt   = {t_r[22:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd23) begin
          state_nxt = ST_SSUM;
        end
      end
      ST_SSUM: begin
        sres_nxt  = '0;
        sbit_nxt  = SQ_W'(1) << 46;
        state_nxt = ST_SQRT;
        if (ssum >= ONE24) begin
          sv_nxt  = ALPHA_ONE;
          tag_nxt = TAG_OUT;
        end else begin
          sv_nxt  = {ssum[23:0], 24'd0};
          tag_nxt = TAG_ALPHA;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          state_nxt = top ? ST_ADV : ST_RD;
        end
      end
      ST_RD: state_nxt = ST_WR;
      ST_WR: begin
        if (complete) begin
          n0_nxt    = 24'(s0 >>> sh);
          n1_nxt    = 24'(s1 >>> sh);
          n2_nxt    = 24'(s2 >>> sh);
          a2_nxt    = 25'(sa >> sh);
          lvl_nxt   = lvl_up;
          cx_nxt    = px;
          cy_nxt    = py;
          base_nxt  = base_r + dim_up;
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        if ({1'b0, cxc_r} >= wlast) begin
          cxc_nxt = '0;
          cyc_nxt = ({1'b0, cyc_r} >= hlast) ? '0 : cyc_r + 10'd1;
        end else begin
          cxc_nxt = cxc_r + 10'd1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      if (cfg_addr) begin
        hl_nxt = (cfg_wdata > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : cfg_wdata;
      end else begin
        wl_nxt = (cfg_wdata > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : cfg_wdata;
      end
      cxc_nxt = '0;
      cyc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wl_r    <= '0;
      hl_r    <= '0;
      cxc_r   <= '0;
      cyc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wl_r    <= wl_nxt;
      hl_r    <= hl_nxt;
      cxc_r   <= cxc_nxt;
      cyc_r   <= cyc_nxt;
    end
    rough_r  <= rough_nxt;
    n0_r     <= n0_nxt;
    n1_r     <= n1_nxt;
    n2_r     <= n2_nxt;
    a2_r     <= a2_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
    sv_r     <= sv_nxt;
    sres_r   <= sres_nxt;
    sbit_r   <= sbit_nxt;
    tag_r    <= tag_nxt;
    r2_r     <= r2_nxt;
    a2c_r    <= a2c_nxt;
    rt_r     <= rt_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    t_r      <= t_nxt;
    lvl_r    <= lvl_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    base_r   <= base_nxt;
    orough_r <= orough_nxt;
  end

endmodule
